@@ rtl/kbsc_pkg.sv @@
// Package with the shared types, register indexes and the substitution ROM contents.
package kbsc_pkg;

   localparam int unsigned DataWidth = 8;
   localparam int unsigned KeyWidth = 32;
   localparam int unsigned CsrDataWidth = 32;
   localparam int unsigned CsrAddrWidth = 3;
   localparam int unsigned RomDepth = 256;

   localparam logic [KeyWidth-1:0] SeedReset = 32'h000b2023;

   localparam int unsigned FillMulInit = 12;
   localparam int unsigned FillMulMod = 35;
   localparam int unsigned FillAddInit = 5;
   localparam int unsigned FillAddMod = 9;
   localparam int unsigned FillAddStep = 2;

   typedef enum logic {
      REG_SEED = 1'b0,
      REG_MODE = 1'b1
   } reg_index_type;

   typedef logic [RomDepth-1:0][DataWidth-1:0] rom_type;

   typedef struct packed {
      logic [KeyWidth-1:0] seed;
      logic                encrypt;
   } cfg_type;

   // The fill rule steps to the next free byte value when a candidate is taken.
   function automatic rom_type fill_table();
      rom_type               tab;
      logic [RomDepth-1:0]   taken;
      int unsigned           mul;
      int unsigned           add;
      logic [31:0]           cand;
      tab = '0;
      taken = '0;
      mul = FillMulInit;
      add = FillAddInit;
      for (int unsigned b = 0; b < RomDepth; b++) begin
         cand = 32'(mul * b + add);
         for (int unsigned k = 0; k < RomDepth; k++) begin
            if (taken[cand[DataWidth-1:0]]) begin
               cand = cand + 32'd1;
               add = add + 1;
            end
         end
         tab[b] = cand[DataWidth-1:0];
         taken[cand[DataWidth-1:0]] = 1'b1;
         mul = (mul + 1) % FillMulMod;
         add = (add + FillAddStep) % FillAddMod;
      end
      return tab;
   endfunction

   localparam rom_type SubstTable = fill_table();

endpackage

@@ rtl/kbsc_req_if.sv @@
// Input channel interface carrying one data word and its block start flag.
interface kbsc_req_if;
   logic                          valid;
   logic                          ready;
   logic [kbsc_pkg::DataWidth-1:0] data_byte;
   logic                          block_start;

   modport source (output valid, output data_byte, output block_start, input ready);
   modport sink (input valid, input data_byte, input block_start, output ready);
endinterface

@@ rtl/kbsc_rsp_if.sv @@
// Result channel interface carrying one transformed word.
interface kbsc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [kbsc_pkg::DataWidth-1:0] result_byte;

   modport source (output valid, output result_byte, input ready);
   modport sink (input valid, input result_byte, output ready);
endinterface

@@ rtl/kbsc_csr.sv @@
// Configuration registers behind the APB-style port.
module kbsc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [kbsc_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  logic [kbsc_pkg::CsrDataWidth-1:0]  csr_pwdata,
   output logic [kbsc_pkg::CsrDataWidth-1:0]  csr_prdata,
   output logic                               csr_pready,
   output kbsc_pkg::cfg_type                  cfg
);
   import kbsc_pkg::*;

   logic [KeyWidth-1:0] seed_ff;
   logic [KeyWidth-1:0] seed_in;
   logic                mode_ff;
   logic                mode_in;
   logic                wr_en;
   reg_index_type       index;

   assign index = reg_index_type'(csr_paddr[CsrAddrWidth-1]);
   assign wr_en = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      seed_in = seed_ff;
      mode_in = mode_ff;
      if (wr_en) begin
         unique case (index)
            REG_SEED: seed_in = csr_pwdata[KeyWidth-1:0];
            REG_MODE: mode_in = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_SEED: csr_prdata = seed_ff;
         REG_MODE: csr_prdata = {{(CsrDataWidth-1){1'b0}}, mode_ff};
         default:  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= SeedReset;
         mode_ff <= 1'b0;
      end else begin
         seed_ff <= seed_in;
         mode_ff <= mode_in;
      end
   end

   assign cfg.seed = seed_ff;
   assign cfg.encrypt = mode_ff;
endmodule

@@ rtl/kbsc_keystream.sv @@
// Keystream register and byte counter that produce the ROM address for each word.
module kbsc_keystream (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic                            block_start,
   input  logic [kbsc_pkg::KeyWidth-1:0]   seed,
   output logic [kbsc_pkg::DataWidth-1:0]  rom_addr
);
   import kbsc_pkg::*;

   logic [KeyWidth-1:0]  key_ff;
   logic [KeyWidth-1:0]  key_in;
   logic [DataWidth-1:0] count_ff;
   logic [DataWidth-1:0] count_in;
   logic [KeyWidth-1:0]  key_cur;
   logic [DataWidth-1:0] count_next;
   logic [KeyWidth-1:0]  key_rot;

   assign key_cur = block_start ? seed : key_ff;
   assign count_next = (block_start ? '0 : count_ff) + DataWidth'(1);
   assign key_rot = {key_cur[KeyWidth-2:0], key_cur[KeyWidth-1]};
   assign rom_addr = key_cur[DataWidth-1:0];

   always_comb begin
      key_in = key_ff;
      count_in = count_ff;
      if (accept) begin
         key_in = {key_rot[KeyWidth-1:DataWidth], key_rot[DataWidth-1:0] ^ count_next};
         count_in = count_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
         count_ff <= '0;
      end else begin
         key_ff <= key_in;
         count_ff <= count_in;
      end
   end
endmodule

@@ rtl/kbsc_rom.sv @@
// Substitution ROM with a registered read port.
module kbsc_rom (
   input  logic                            clock,
   input  logic                            rd_en,
   input  logic [kbsc_pkg::DataWidth-1:0]  rd_addr,
   output logic [kbsc_pkg::DataWidth-1:0]  rd_data
);
   import kbsc_pkg::*;

   logic [DataWidth-1:0] mem [RomDepth];
   logic [DataWidth-1:0] rd_data_ff;

   always_comb begin
      for (int unsigned i = 0; i < RomDepth; i++) begin
         mem[i] = SubstTable[i];
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/keyed_byte_stream_cipher.sv @@
// Top level of the keyed byte stream cipher.
// The block takes one word per clock while rsp is not stalled and returns one word per
// accepted word, in order. At the edge that accepts a word, its ROM byte is read into the
// registered substitution ROM. When the word leaves the first stage, it is combined with
// that byte and loaded into an output register, which presents the result on rsp and
// holds it until the rsp side is ready. The keystream register and the byte counter
// advance at acceptance, which lets a new word enter every cycle while the output is not
// stalled. The single ROM read port sets the rate of one word per clock. Write the seed
// and the mode only while no words are in flight.
module keyed_byte_stream_cipher (
   input  logic                               clock,
   input  logic                               reset,
   kbsc_req_if.sink                           req,
   kbsc_rsp_if.source                         rsp,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [kbsc_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  logic [kbsc_pkg::CsrDataWidth-1:0]  csr_pwdata,
   output logic [kbsc_pkg::CsrDataWidth-1:0]  csr_prdata,
   output logic                               csr_pready
);
   import kbsc_pkg::*;

   cfg_type              cfg;
   logic [DataWidth-1:0] rom_addr;
   logic [DataWidth-1:0] rom_data;
   logic                 accept;
   logic                 s1_adv;
   logic                 out_free;

   logic                 s1_vld_ff;
   logic                 s1_vld_in;
   logic [DataWidth-1:0] s1_data_ff;
   logic [DataWidth-1:0] s1_data_in;
   logic                 s1_enc_ff;
   logic                 s1_enc_in;
   logic                 out_vld_ff;
   logic                 out_vld_in;
   logic [DataWidth-1:0] out_data_ff;
   logic [DataWidth-1:0] out_data_in;

   kbsc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   kbsc_keystream u_keystream (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .block_start (req.block_start),
      .seed        (cfg.seed),
      .rom_addr    (rom_addr)
   );

   kbsc_rom u_rom (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (rom_addr),
      .rd_data (rom_data)
   );

   assign out_free = !out_vld_ff || rsp.ready;
   assign s1_adv = s1_vld_ff && out_free;
   assign req.ready = !s1_vld_ff || out_free;
   assign accept = req.valid && req.ready;

   always_comb begin
      s1_vld_in = s1_vld_ff;
      s1_data_in = s1_data_ff;
      s1_enc_in = s1_enc_ff;
      if (accept) begin
         s1_vld_in = 1'b1;
         s1_data_in = req.data_byte;
         s1_enc_in = cfg.encrypt;
      end else if (s1_adv) begin
         s1_vld_in = 1'b0;
      end
   end

   always_comb begin
      out_vld_in = out_vld_ff;
      out_data_in = out_data_ff;
      if (s1_adv) begin
         out_vld_in = 1'b1;
         out_data_in = s1_enc_ff ? s1_data_ff + rom_data : s1_data_ff - rom_data;
      end else if (rsp.ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff <= s1_data_in;
      s1_enc_ff <= s1_enc_in;
      out_data_ff <= out_data_in;
   end

   assign rsp.valid = out_vld_ff;
   assign rsp.result_byte = out_data_ff;
endmodule

@@ rtl/kbsc_checker.sv @@
// Port-level checker for the cipher top level and the bind that attaches it.
module kbsc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [kbsc_pkg::DataWidth-1:0]  rsp_result_byte
);
   import kbsc_pkg::*;

   property p_rsp_hold_valid;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_ready |=> rsp_valid;
   endproperty

   property p_rsp_hold_data;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_ready |=> $stable(rsp_result_byte);
   endproperty

   property p_reset_clears_output;
      @(posedge clock) reset |=> !rsp_valid;
   endproperty

   property p_ready_when_output_empty;
      @(posedge clock) disable iff (reset)
         !rsp_valid |-> req_ready;
   endproperty

   a_rsp_hold_valid: assert property (p_rsp_hold_valid)
      else $error("Result word dropped while stalled.");
   a_rsp_hold_data: assert property (p_rsp_hold_data)
      else $error("Result word changed while stalled.");
   a_reset_clears_output: assert property (p_reset_clears_output)
      else $error("Result valid after reset.");
   a_ready_when_output_empty: assert property (p_ready_when_output_empty)
      else $error("Input stalled while the output register is empty.");
endmodule

bind keyed_byte_stream_cipher kbsc_checker u_kbsc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req.valid),
   .req_ready       (req.ready),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_result_byte (rsp.result_byte)
);

@@ bench/tb_top.sv @@
// Self-checking bench for the keyed byte stream cipher, with its own keystream tracker.
class keystream_tracker;
   logic [7:0]  subst_rom [256];
   logic [31:0] keystream;
   logic [7:0]  word_count;
   logic [31:0] seed;
   logic        encrypt;
   logic [7:0]  expected_bytes [$];
   int          errors;

   function new();
      bit          taken [256];
      int unsigned mul;
      int unsigned add;
      int unsigned cand;
      mul = 12;
      add = 5;
      for (int b = 0; b < 256; b++) begin
         taken[b] = 1'b0;
      end
      for (int unsigned b = 0; b < 256; b++) begin
         cand = mul * b + add;
         while (taken[cand & 8'hff]) begin
            cand++;
            add++;
         end
         subst_rom[b] = cand[7:0];
         taken[cand & 8'hff] = 1'b1;
         mul = (mul + 1) % 35;
         add = (add + 2) % 9;
      end
      keystream = '0;
      word_count = '0;
      seed = 32'h000b2023;
      encrypt = 1'b0;
      errors = 0;
   endfunction

   function void set_register(kbsc_pkg::reg_index_type idx, logic [31:0] value);
      case (idx)
         kbsc_pkg::REG_SEED: seed = value;
         kbsc_pkg::REG_MODE: encrypt = value[0];
         default: ;
      endcase
   endfunction

   function void note_word(logic [7:0] data, logic start);
      logic [7:0]  key_byte;
      logic [7:0]  outcome;
      logic [31:0] rotated;
      if (start) begin
         keystream = seed;
         word_count = '0;
      end
      key_byte = subst_rom[keystream[7:0]];
      outcome = encrypt ? data + key_byte : data - key_byte;
      expected_bytes.push_back(outcome);
      word_count = word_count + 8'd1;
      rotated = {keystream[30:0], keystream[31]};
      keystream = {rotated[31:8], rotated[7:0] ^ word_count};
   endfunction

   function void report(string msg);
      $display("mismatch: %s", msg);
      errors++;
   endfunction

   function void check_word(logic [7:0] got);
      logic [7:0] want;
      if (expected_bytes.size() == 0) begin
         report($sformatf("result word %02h arrived with nothing outstanding", got));
      end else begin
         want = expected_bytes.pop_front();
         if (got !== want) begin
            report($sformatf("result_byte %02h, expected %02h", got, want));
         end
      end
   endfunction
endclass

module tb_top;
   import kbsc_pkg::*;

   logic                    clock;
   logic                    reset;
   logic                    csr_psel;
   logic                    csr_penable;
   logic                    csr_pwrite;
   logic [CsrAddrWidth-1:0] csr_paddr;
   logic [CsrDataWidth-1:0] csr_pwdata;
   logic [CsrDataWidth-1:0] csr_prdata;
   logic                    csr_pready;
   int                      send_idle_pct;
   int                      recv_stall_pct;
   keystream_tracker        tracker;

   kbsc_req_if req_if ();
   kbsc_rsp_if rsp_if ();

   keyed_byte_stream_cipher uut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever begin
         #5 clock = ~clock;
      end
   end

   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         tracker.check_word(rsp_if.result_byte);
      end
   end

   task automatic send_word(input logic [7:0] data, input logic start);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data_byte <= data;
      req_if.block_start <= start;
      @(posedge clock);
      while (!req_if.ready) begin
         @(posedge clock);
      end
      tracker.note_word(data, start);
      @(negedge clock);
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (tracker.expected_bytes.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CsrAddrWidth'(int'(idx) * 4);
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      tracker.set_register(idx, value);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Blocks are mostly short; some run past 256 words so the counter wraps, and some
   // begin without a block start so the previous keystream carries on.
   task automatic run_blocks(input int count, input bit long_first);
      int sent;
      int len;
      bit lead;
      sent = 0;
      while (sent < count) begin
         if (long_first && sent == 0) begin
            len = 300;
         end else if ($urandom_range(19) == 0) begin
            len = $urandom_range(400, 257);
         end else begin
            len = $urandom_range(24, 1);
         end
         lead = ($urandom_range(7) != 0);
         for (int i = 0; i < len; i++) begin
            send_word(8'($urandom_range(255)), (i == 0) && lead);
         end
         sent += len;
      end
   endtask

   initial begin
      tracker = new();
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.data_byte = '0;
      req_if.block_start = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Words before any block start use the cleared keystream.
      send_word(8'h00, 1'b0);
      send_word(8'hff, 1'b0);
      send_word(8'h5a, 1'b0);
      send_word(8'hff, 1'b1);
      send_word(8'h00, 1'b0);
      send_word(8'h80, 1'b0);
      send_word(8'h01, 1'b0);
      drain();
      write_reg(REG_MODE, 32'h1);
      send_word(8'h00, 1'b1);
      send_word(8'hff, 1'b0);
      send_word(8'h7f, 1'b0);
      send_word(8'h80, 1'b0);
      drain();
      // A new seed must not disturb the block already under way.
      write_reg(REG_SEED, 32'hffffffff);
      send_word(8'hc3, 1'b0);
      send_word(8'h3c, 1'b0);
      send_word(8'h00, 1'b1);
      send_word(8'hff, 1'b0);
      drain();
      write_reg(REG_SEED, 32'h0);
      write_reg(REG_MODE, 32'h0);
      send_word(8'haa, 1'b1);
      send_word(8'h55, 1'b0);
      send_word(8'hff, 1'b1);
      send_word(8'h00, 1'b1);

      for (int phase = 0; phase < 4; phase++) begin
         drain();
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
            default: begin send_idle_pct = 29; recv_stall_pct = 29; end
         endcase
         for (int half = 0; half < 2; half++) begin
            drain();
            if (phase == 0 && half == 0) begin
               write_reg(REG_SEED, 32'hffffffff);
            end else if (phase == 1 && half == 0) begin
               write_reg(REG_SEED, 32'h0);
            end else begin
               write_reg(REG_SEED, $urandom());
            end
            write_reg(REG_MODE, 32'(half ^ (phase & 1)));
            run_blocks(180, phase == 0 && half == 0);
         end
      end

      drain();
      repeat (10) @(posedge clock);
      if (tracker.errors == 0) begin
         $display("** keyed_byte_stream_cipher: PASSED **");
      end else begin
         $display("** keyed_byte_stream_cipher: FAILED **");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("** keyed_byte_stream_cipher: FAILED **");
      $finish;
   end
endmodule
